// ----- src/gpdm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpdm_pkg
// Shared types, register map, flag colours and gamma ROMs of the mapper.
// ----------------------------------------------------------------------------
package gpdm_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes (byte address bits 3:2)
    localparam logic [1:0] REG_DISPLAY_MODE  = 2'd0;
    localparam logic [1:0] REG_INVERT_OUTPUT = 2'd1;
    localparam logic [1:0] REG_SWAP_BYTES    = 2'd2;

    // display modes
    localparam logic [1:0] MODE_LINEAR     = 2'd0;
    localparam logic [1:0] MODE_SAT_FLAGS  = 2'd1;
    localparam logic [1:0] MODE_GAMMA_LOW  = 2'd2;
    localparam logic [1:0] MODE_GAMMA_HIGH = 2'd3;

    localparam logic [7:0] SAT_DARK_LIMIT = 8'd168;
    localparam logic [7:0] SAT_RED_LIMIT  = 8'd250;
    localparam logic [7:0] SAT_DARK_RED   = 8'h33;
    localparam logic [7:0] SAT_RED        = 8'hCC;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } t_bgr;

    typedef struct packed {
        logic vld;
        logic adv;
    } t_stage_ctl;

    typedef logic [255:0][7:0] t_gamma_rom;

    // entry g: largest v with v^20 <= g^ge * 255^fe, i.e. floor(255*(g/255)^(ge/20))
    function automatic t_gamma_rom gamma_rom(input int ge, input int fe);
        t_gamma_rom   rom;
        logic [167:0] bound;
        logic [167:0] trial;
        logic [7:0]   v;
        logic [7:0]   cand;
        for (int g = 0; g < 256; g++) begin
            bound = 168'd1;
            for (int k = 0; k < ge; k++) bound = bound * 168'(g);
            for (int k = 0; k < fe; k++) bound = bound * 168'd255;
            v = 8'd0;
            for (int bt = 7; bt >= 0; bt--) begin
                cand = v | (8'd1 << bt);
                trial = 168'd1;
                for (int k = 0; k < 20; k++) trial = trial * 168'(cand);
                if (trial <= bound) v = cand;
            end
            rom[g] = v;
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_LOW_ROM  = gamma_rom(9, 11);
    localparam t_gamma_rom GAMMA_HIGH_ROM = gamma_rom(7, 13);

endpackage
`default_nettype wire

// ----- src/gray_pixel_display_mapper_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gray_pixel_display_mapper_core
// Maps pairs of 16-bit gray pixels to BGR display triples.
// ----------------------------------------------------------------------------
// One item (a 32-bit word of two pixels) is accepted every cycle unless
// o_stall is high; each item passes through a three-stage pipeline of
// byte selection, mode mapping (flag compare or gamma ROM lookup) and
// inversion. Stages that hold no item are filled while the output stalls.
// Registers at byte addresses 0 (display_mode), 4 (invert_output) and
// 8 (swap_bytes) must be written only while the pipeline is empty; the
// block itself does not enforce this.
module gray_pixel_display_mapper_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [gpdm_pkg::ADDR_W-1:0]   paddr,
    input  wire [gpdm_pkg::DATA_W-1:0]   pwdata,
    output logic [gpdm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [31:0]                   i_pixel_pair,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [7:0]                   o_first_blue,
    output logic [7:0]                   o_first_green,
    output logic [7:0]                   o_first_red,
    output logic [7:0]                   o_second_blue,
    output logic [7:0]                   o_second_green,
    output logic [7:0]                   o_second_red
);
    import gpdm_pkg::*;

    logic [1:0] r_display_mode;
    logic       r_invert_output;
    logic       r_swap_bytes;
    logic       w_wr;

    logic       w_vld1;
    logic       w_vld2;
    logic       w_vld3;
    logic       w_adv1;
    logic       w_adv2;
    logic       w_adv3;
    t_stage_ctl w_ctl1;
    t_stage_ctl w_ctl2;
    t_stage_ctl w_ctl3;
    logic [7:0] w_gray_first;
    logic [7:0] w_gray_second;
    t_bgr       w_map_first;
    t_bgr       w_map_second;
    t_bgr       w_out_first;
    t_bgr       w_out_second;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode  <= MODE_LINEAR;
            r_invert_output <= 1'b0;
            r_swap_bytes    <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_DISPLAY_MODE:  r_display_mode  <= pwdata[1:0];
                REG_INVERT_OUTPUT: r_invert_output <= pwdata[0];
                REG_SWAP_BYTES:    r_swap_bytes    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DISPLAY_MODE:  prdata = {{(DATA_W-2){1'b0}}, r_display_mode};
            REG_INVERT_OUTPUT: prdata = {{(DATA_W-1){1'b0}}, r_invert_output};
            REG_SWAP_BYTES:    prdata = {{(DATA_W-1){1'b0}}, r_swap_bytes};
            default:           prdata = '0;
        endcase
    end

    // a stage takes a new item when it is empty or its content moves on
    assign w_adv3  = !w_vld3 || !i_stall;
    assign w_adv2  = !w_vld2 || w_adv3;
    assign w_adv1  = !w_vld1 || w_adv2;
    assign o_stall = !w_adv1;

    assign w_ctl1 = '{vld: i_valid, adv: w_adv1};
    assign w_ctl2 = '{vld: w_vld1,  adv: w_adv2};
    assign w_ctl3 = '{vld: w_vld2,  adv: w_adv3};

    gpdm_unpack u_unpack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl1),
        .i_swap_bytes  (r_swap_bytes),
        .i_pixel_pair  (i_pixel_pair),
        .o_vld         (w_vld1),
        .o_gray_first  (w_gray_first),
        .o_gray_second (w_gray_second)
    );

    gpdm_map u_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl2),
        .i_display_mode (r_display_mode),
        .i_gray_first   (w_gray_first),
        .i_gray_second  (w_gray_second),
        .o_vld          (w_vld2),
        .o_first        (w_map_first),
        .o_second       (w_map_second)
    );

    gpdm_invert u_invert (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl3),
        .i_invert_output (r_invert_output),
        .i_first         (w_map_first),
        .i_second        (w_map_second),
        .o_vld           (w_vld3),
        .o_first         (w_out_first),
        .o_second        (w_out_second)
    );

    assign o_valid        = w_vld3;
    assign o_first_blue   = w_out_first.b;
    assign o_first_green  = w_out_first.g;
    assign o_first_red    = w_out_first.r;
    assign o_second_blue  = w_out_second.b;
    assign o_second_green = w_out_second.g;
    assign o_second_red   = w_out_second.r;

endmodule
`default_nettype wire

// ----- src/gpdm_unpack.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpdm_unpack
// Stage 1: picks the gray byte of each pixel, with optional byte swap.
// ----------------------------------------------------------------------------
module gpdm_unpack (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  gpdm_pkg::t_stage_ctl i_ctl,
    input  wire                  i_swap_bytes,
    input  wire [31:0]           i_pixel_pair,
    output logic                 o_vld,
    output logic [7:0]           o_gray_first,
    output logic [7:0]           o_gray_second
);
    import gpdm_pkg::*;

    logic       r_vld;
    logic [7:0] r_gray_first;
    logic [7:0] r_gray_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_gray_first  <= i_swap_bytes ? i_pixel_pair[7:0]   : i_pixel_pair[15:8];
            r_gray_second <= i_swap_bytes ? i_pixel_pair[23:16] : i_pixel_pair[31:24];
        end
    end

    assign o_vld         = r_vld;
    assign o_gray_first  = r_gray_first;
    assign o_gray_second = r_gray_second;

endmodule
`default_nettype wire

// ----- src/gpdm_map.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpdm_map
// Stage 2: maps both gray bytes to BGR by display mode.
// ----------------------------------------------------------------------------
module gpdm_map (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  gpdm_pkg::t_stage_ctl i_ctl,
    input  wire [1:0]            i_display_mode,
    input  wire [7:0]            i_gray_first,
    input  wire [7:0]            i_gray_second,
    output logic                 o_vld,
    output gpdm_pkg::t_bgr       o_first,
    output gpdm_pkg::t_bgr       o_second
);
    import gpdm_pkg::*;

    logic r_vld;
    t_bgr r_first;
    t_bgr r_second;
    t_bgr n_first;
    t_bgr n_second;

    function automatic t_bgr map_gray(input logic [1:0] mode, input logic [7:0] gray);
        t_bgr res;
        unique case (mode)
            MODE_LINEAR: res = '{b: gray, g: gray, r: gray};
            MODE_SAT_FLAGS: begin
                priority if (gray < SAT_DARK_LIMIT) begin
                    res = '{b: gray, g: gray, r: gray};
                end else if (gray < SAT_RED_LIMIT) begin
                    res = '{b: 8'd0, g: 8'd0, r: SAT_DARK_RED};
                end else begin
                    res = '{b: 8'd0, g: 8'd0, r: SAT_RED};
                end
            end
            MODE_GAMMA_LOW:  res = '{b: GAMMA_LOW_ROM[gray], g: GAMMA_LOW_ROM[gray],
                                     r: GAMMA_LOW_ROM[gray]};
            MODE_GAMMA_HIGH: res = '{b: GAMMA_HIGH_ROM[gray], g: GAMMA_HIGH_ROM[gray],
                                     r: GAMMA_HIGH_ROM[gray]};
            default:         res = '{b: gray, g: gray, r: gray};
        endcase
        return res;
    endfunction

    always_comb begin
        n_first  = map_gray(i_display_mode, i_gray_first);
        n_second = map_gray(i_display_mode, i_gray_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    assign o_vld    = r_vld;
    assign o_first  = r_first;
    assign o_second = r_second;

endmodule
`default_nettype wire

// ----- src/gpdm_invert.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpdm_invert
// Stage 3: optional inversion, output register of the block.
// ----------------------------------------------------------------------------
module gpdm_invert (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  gpdm_pkg::t_stage_ctl i_ctl,
    input  wire                  i_invert_output,
    input  gpdm_pkg::t_bgr       i_first,
    input  gpdm_pkg::t_bgr       i_second,
    output logic                 o_vld,
    output gpdm_pkg::t_bgr       o_first,
    output gpdm_pkg::t_bgr       o_second
);
    import gpdm_pkg::*;

    logic r_vld;
    t_bgr r_first;
    t_bgr r_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_ctl.vld;
        end
    end

    // 255 - x is the bitwise complement
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_first  <= i_invert_output ? ~i_first  : i_first;
            r_second <= i_invert_output ? ~i_second : i_second;
        end
    end

    assign o_vld    = r_vld;
    assign o_first  = r_first;
    assign o_second = r_second;

endmodule
`default_nettype wire

// ----- verif/gpdm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpdm_checker
// Watches the mapper's register port and both item channels. It keeps its
// own copy of the mapping registers, predicts the BGR pair for every
// accepted item and compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
module gpdm_checker (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire                          pready,
    input  wire [gpdm_pkg::ADDR_W-1:0]   paddr,
    input  wire [gpdm_pkg::DATA_W-1:0]   pwdata,
    input  wire                          in_valid,
    input  wire                          in_stall,
    input  wire [31:0]                   pixel_pair,
    input  wire                          out_valid,
    input  wire                          out_stall,
    input  wire [7:0]                    first_blue,
    input  wire [7:0]                    first_green,
    input  wire [7:0]                    first_red,
    input  wire [7:0]                    second_blue,
    input  wire [7:0]                    second_green,
    input  wire [7:0]                    second_red,
    output int                           mismatches,
    output int                           pending,
    output int                           checked
);
    import gpdm_pkg::*;

    localparam logic [7:0] DARK_FROM  = 8'd168;
    localparam logic [7:0] RED_FROM   = 8'd250;
    localparam logic [7:0] DARK_RED_R = 8'h33;
    localparam logic [7:0] RED_R      = 8'hCC;

    typedef struct packed {
        t_bgr first;
        t_bgr second;
    } t_bgr_pair;

    t_bgr_pair   pair_q[$];
    logic [1:0]  mode_r;
    logic        invert_r;
    logic        swap_r;
    logic [7:0]  gamma45_lut [256];
    logic [7:0]  gamma35_lut [256];
    int          err_n;
    int          chk_n;

    initial begin
        mismatches = 0;
        pending    = 0;
        checked    = 0;
        err_n      = 0;
        chk_n      = 0;
        mode_r     = MODE_LINEAR;
        invert_r   = 1'b0;
        swap_r     = 1'b0;
    end

    function automatic logic [175:0] pow20(input int unsigned v);
        logic [175:0] p;
        p = 176'd1;
        repeat (20) p = p * 176'(v);
        return p;
    endfunction

    // gray^num * 255^(20-num): v^20 at or below it means v <= 255*(gray/255)^(num/20)
    function automatic logic [175:0] gamma_bound(input int unsigned gray,
                                                 input int unsigned num);
        logic [175:0] p;
        p = 176'd1;
        repeat (num) p = p * 176'(gray);
        repeat (20 - num) p = p * 176'd255;
        return p;
    endfunction

    // curve is monotonic, so each entry starts from the previous one
    initial begin : build_luts
        logic [175:0] lim45;
        logic [175:0] lim35;
        int unsigned  v45;
        int unsigned  v35;
        v45 = 0;
        v35 = 0;
        for (int g = 0; g < 256; g++) begin
            lim45 = gamma_bound(g, 9);
            lim35 = gamma_bound(g, 7);
            while (v45 < 255 && pow20(v45 + 1) <= lim45) v45++;
            while (v35 < 255 && pow20(v35 + 1) <= lim35) v35++;
            gamma45_lut[g] = 8'(v45);
            gamma35_lut[g] = 8'(v35);
        end
    end

    function automatic t_bgr shade(input logic [7:0] gray);
        t_bgr c;
        case (mode_r)
            MODE_LINEAR: c = '{gray, gray, gray};
            MODE_SAT_FLAGS: begin
                if (gray < DARK_FROM)
                    c = '{gray, gray, gray};
                else if (gray < RED_FROM)
                    c = '{8'h00, 8'h00, DARK_RED_R};
                else
                    c = '{8'h00, 8'h00, RED_R};
            end
            MODE_GAMMA_LOW: c = '{gamma45_lut[gray], gamma45_lut[gray], gamma45_lut[gray]};
            default: c = '{gamma35_lut[gray], gamma35_lut[gray], gamma35_lut[gray]};
        endcase
        if (invert_r)
            c = ~c;
        return c;
    endfunction

    always @(posedge clk) begin : watch
        t_bgr_pair want;
        t_bgr_pair seen;
        int        bad;
        if (!rst_n) begin
            mode_r   <= MODE_LINEAR;
            invert_r <= 1'b0;
            swap_r   <= 1'b0;
            pair_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_DISPLAY_MODE:  mode_r   <= pwdata[1:0];
                    REG_INVERT_OUTPUT: invert_r <= pwdata[0];
                    REG_SWAP_BYTES:    swap_r   <= pwdata[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                if (swap_r) begin
                    want.first  = shade(pixel_pair[7:0]);
                    want.second = shade(pixel_pair[23:16]);
                end else begin
                    want.first  = shade(pixel_pair[15:8]);
                    want.second = shade(pixel_pair[31:24]);
                end
                pair_q.push_back(want);
            end
            if (out_valid && !out_stall) begin
                seen = '{'{first_blue, first_green, first_red},
                         '{second_blue, second_green, second_red}};
                chk_n++;
                if (pair_q.size() == 0) begin
                    err_n++;
                    if (err_n <= 10)
                        $display("unexpected result %0d: %h", chk_n, seen);
                end else begin
                    want = pair_q.pop_front();
                    bad = int'(seen.first.b !== want.first.b)
                        + int'(seen.first.g !== want.first.g)
                        + int'(seen.first.r !== want.first.r)
                        + int'(seen.second.b !== want.second.b)
                        + int'(seen.second.g !== want.second.g)
                        + int'(seen.second.r !== want.second.r);
                    if (bad != 0) begin
                        err_n++;
                        if (err_n <= 10) begin
                            $display("mismatch on result %0d (%0d fields): expected B/G/R %h %h %h | %h %h %h",
                                     chk_n, bad,
                                     want.first.b, want.first.g, want.first.r,
                                     want.second.b, want.second.g, want.second.r);
                            $display("    got %h %h %h | %h %h %h",
                                     seen.first.b, seen.first.g, seen.first.r,
                                     seen.second.b, seen.second.g, seen.second.r);
                        end
                    end
                end
            end
        end
        mismatches <= err_n;
        pending    <= pair_q.size();
        checked    <= chk_n;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the gray pixel mapper: a directed set around the flag thresholds
// and byte extremes, then bursty random pixel pairs in each display mode
// with inversion on and off, random output stalls, checked in gpdm_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import gpdm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 125;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [ADDR_W-1:0]    paddr        = '0;
    logic [DATA_W-1:0]    pwdata       = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    logic [31:0]          i_pixel_pair = '0;
    logic                 o_valid;
    logic                 i_stall      = 1'b0;
    logic [7:0]           o_first_blue, o_first_green, o_first_red;
    logic [7:0]           o_second_blue, o_second_green, o_second_red;

    int                   mismatches, pending, checked;
    int                   items_sent = 0;
    int                   settings_used = 0;
    int                   cycles = 0;
    int                   stall_style = 0;
    int                   style_left = 0;
    int unsigned          tick = 0;

    logic [1:0] mode_cycle [4] = '{MODE_LINEAR, MODE_SAT_FLAGS, MODE_GAMMA_LOW,
                                   MODE_GAMMA_HIGH};

    always #4 i_clk = ~i_clk;

    gray_pixel_display_mapper_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_pair   (i_pixel_pair),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_first_blue   (o_first_blue),
        .o_first_green  (o_first_green),
        .o_first_red    (o_first_red),
        .o_second_blue  (o_second_blue),
        .o_second_green (o_second_green),
        .o_second_red   (o_second_red)
    );

    gpdm_checker u_check (
        .clk          (i_clk),
        .rst_n        (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (i_valid),
        .in_stall     (o_stall),
        .pixel_pair   (i_pixel_pair),
        .out_valid    (o_valid),
        .out_stall    (i_stall),
        .first_blue   (o_first_blue),
        .first_green  (o_first_green),
        .first_red    (o_first_red),
        .second_blue  (o_second_blue),
        .second_green (o_second_green),
        .second_red   (o_second_red),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked)
    );

    // receiver: picks a new random stall style whenever the current one runs out
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(40, 300);
        end
        style_left--;
        tick++;
        case (stall_style)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= ((tick % 11) < 4);
        endcase
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // leaves the bus selected after the access; the caller idles it
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic set_mapping(input logic [1:0] mode, input logic inv, input logic swap);
        write_reg(REG_DISPLAY_MODE, {30'd0, mode});
        write_reg(REG_INVERT_OUTPUT, {31'd0, inv});
        write_reg(REG_SWAP_BYTES, {31'd0, swap});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task automatic push_pair(input logic [31:0] w);
        i_valid      <= 1'b1;
        i_pixel_pair <= w;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // stop sending and let every outstanding item come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // biased towards the flag thresholds and the byte extremes
    function automatic logic [7:0] near_edge_byte();
        case ($urandom_range(0, 5))
            3: return 8'($urandom_range(160, 175));
            4: return 8'($urandom_range(244, 255));
            5: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        if ($urandom_range(0, 2) == 0)
            return $urandom();
        return {near_edge_byte(), near_edge_byte(), near_edge_byte(), near_edge_byte()};
    endfunction

    task automatic random_run(input int n);
        int left;
        int burst;
        int gap;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) begin
                push_pair(rand_word());
                left--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // flag thresholds, each pixel on its own gray
        set_mapping(MODE_SAT_FLAGS, 1'b0, 1'b0);
        push_pair(32'h0000_FFFF);
        push_pair(32'hFFFF_0000);
        push_pair(32'hA700_A8FF);
        push_pair(32'hF9FF_FA00);
        push_pair(32'hFA12_F934);
        push_pair(32'hA834_A7FF);
        drain();
        set_mapping(MODE_SAT_FLAGS, 1'b1, 1'b1);
        push_pair(32'h12FA_34A7);
        push_pair(32'hFFA8_00F9);
        push_pair(32'h0000_FFFF);
        drain();
        set_mapping(MODE_GAMMA_LOW, 1'b0, 1'b0);
        push_pair(32'hFFFF_0000);
        push_pair(32'h0100_8000);
        push_pair(32'h7F00_FE00);
        drain();
        set_mapping(MODE_GAMMA_HIGH, 1'b1, 1'b1);
        push_pair(32'h00FF_FF00);
        push_pair(32'h0001_0080);
        push_pair(32'hFF7F_00FE);
        drain();
        set_mapping(MODE_LINEAR, 1'b1, 1'b0);
        push_pair(32'hFFFF_0000);
        push_pair(32'h5A5A_A5A5);
        drain();

        for (int p = 0; p < 10; p++) begin
            if (p < 8)
                set_mapping(mode_cycle[p % 4], 1'((p / 4) % 2), 1'((p / 2) % 2));
            else
                set_mapping(mode_cycle[$urandom_range(0, 3)], 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            random_run(PHASE_ITEMS / 2);
            drain();
            random_run(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("sent %0d pixel pairs under %0d register settings, %0d results checked",
                 items_sent, settings_used, checked);
        $display("all display modes seen with inversion and byte swap both on and off");
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
